[hdl/mtg_pkg.sv]
// mtg_pkg: shared constants, types and tempering function of the twister generator
// used by the top level, front, back and testbench; depends on nothing
package mtg_pkg;

   localparam int STATE_DEPTH   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int SHIFT_U       = 11;
   localparam int SHIFT_S       = 7;
   localparam int SHIFT_T       = 15;
   localparam int SHIFT_L       = 18;

   localparam int ADDR_W  = $clog2(STATE_DEPTH);
   localparam int IDX_W   = $clog2(STATE_DEPTH + 1);
   localparam int MID_MOD = MIDDLE_OFFSET % STATE_DEPTH;

   localparam logic [31:0] SEED_FACTOR   = 32'd1812433253;
   localparam int          DISCARD_COUNT = 37;
   localparam int          DISC_W        = $clog2(DISCARD_COUNT + 1);
   localparam int          SEED_SHIFT    = 30;
   localparam logic [31:0] UPPER_BIT     = 32'h8000_0000;
   localparam logic [31:0] LOWER_BITS    = 32'h7FFF_FFFF;

   localparam logic [1:0] MODE_SEED  = 2'd0;
   localparam logic [1:0] MODE_RAW   = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [1:0] REG_TWIST   = 2'd0;
   localparam logic [1:0] REG_TEMPERB = 2'd1;
   localparam logic [1:0] REG_TEMPERC = 2'd2;

   typedef enum logic [2:0] {
      CMD_SEED,
      CMD_RAW,
      CMD_RANGE,
      CMD_EQUAL,
      CMD_ERROR
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] data;
      logic [32:0] span;
   } entry_type;

   typedef struct packed {
      logic [31:0] twist_matrix;
      logic [31:0] mask_b;
      logic [31:0] mask_c;
   } cfg_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SEED_MUL,
      B_SEED_WR,
      B_DRAW,
      B_TW_A,
      B_TW_B,
      B_TW_C,
      B_TW_W,
      B_RD_DATA,
      B_MUL,
      B_ADD
   } back_state_type;

   function automatic logic [31:0] temper(input logic [31:0] w, input cfg_type cfg);
      logic [31:0] y;
      y = w ^ (w >> SHIFT_U);
      y = y ^ ((y << SHIFT_S) & cfg.mask_b);
      y = y ^ ((y << SHIFT_T) & cfg.mask_c);
      y = y ^ (y >> SHIFT_L);
      return y;
   endfunction

endpackage

[hdl/mersenne_twister_generator.sv]
// mersenne_twister_generator: top level, configuration registers and the two halves
// depends on mtg_pkg, mtg_front, mtg_back and mtg_ram
//
// A user pushes request words (seed, raw word, ranged integer) and pops one result
// word per raw or ranged request; seeds and mode 3 give no result. A raw draw passes
// through the draw and read states, a ranged draw also through a multiply and an add
// state. Every 624th draw first twists the whole store, reading three state words and
// writing one for each word. A seed fills the store with a multiply and a write per
// word and then discards 37 draws including one twist. Requests with equal or
// reversed bounds answer from the idle state without using a word. Up to two requests
// queue ahead of the back end while it works.
module mersenne_twister_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_mode,
   input  logic [31:0]          req_seed_value,
   input  logic signed [31:0]   req_low_bound,
   input  logic signed [31:0]   req_high_bound,
   output logic                 empty,
   input  logic                 pop,
   output logic [31:0]          rsp_random_word,
   output logic signed [31:0]   rsp_ranged_value,
   output logic                 rsp_range_error,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   mtg_pkg::cfg_type   cfg_ff, cfg_in;
   mtg_pkg::entry_type q_entry;
   logic               q_valid, q_take;
   logic               wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (paddr[3:2])
            mtg_pkg::REG_TWIST:   cfg_in.twist_matrix = pwdata;
            mtg_pkg::REG_TEMPERB: cfg_in.mask_b       = pwdata;
            mtg_pkg::REG_TEMPERC: cfg_in.mask_c       = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         mtg_pkg::REG_TWIST:   prdata = cfg_ff.twist_matrix;
         mtg_pkg::REG_TEMPERB: prdata = cfg_ff.mask_b;
         mtg_pkg::REG_TEMPERC: prdata = cfg_ff.mask_c;
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.twist_matrix <= 32'h9908_B0DF;
         cfg_ff.mask_b       <= 32'h9D2C_5680;
         cfg_ff.mask_c       <= 32'hEFC6_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_seed_value (req_seed_value),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_take         (q_take)
   );

   mtg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_take           (q_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_random_word  (rsp_random_word),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_range_error  (rsp_range_error)
   );

   // an error word carries the fixed error value and no drawn word
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_range_error) |->
         (rsp_ranged_value == 32'sh8000_0000 && rsp_random_word == 32'd0))
      else $error("error word with wrong payload");

   // reset leaves both queues empty
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a waiting result word stays put until it is popped
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=>
         (!empty && $stable(rsp_random_word) && $stable(rsp_ranged_value)
          && $stable(rsp_range_error)))
      else $error("result word changed while waiting");

endmodule

[hdl/mtg_ram.sv]
// mtg_ram: generic single write, single read RAM with registered read data
// no dependencies
module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mtg_front.sv]
// mtg_front: accepts request words, classifies them and queues them for the back end
// depends on mtg_pkg
module mtg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_mode,
   input  logic [31:0]           req_seed_value,
   input  logic signed [31:0]    req_low_bound,
   input  logic signed [31:0]    req_high_bound,
   output logic                  q_valid,
   output mtg_pkg::entry_type    q_entry,
   input  logic                  q_take
);

   mtg_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   mtg_pkg::entry_type new_entry;
   logic               keep;
   logic               accept;
   logic signed [32:0] diff;

   always_comb begin
      diff           = {req_high_bound[31], req_high_bound} - {req_low_bound[31], req_low_bound};
      new_entry.span = 33'(diff + 33'sd1);
      new_entry.data = req_low_bound;
      keep           = 1'b1;
      new_entry.cmd  = mtg_pkg::CMD_RAW;
      unique case (req_mode)
         mtg_pkg::MODE_SEED: begin
            new_entry.cmd  = mtg_pkg::CMD_SEED;
            new_entry.data = req_seed_value;
         end
         mtg_pkg::MODE_RAW: begin
            new_entry.cmd = mtg_pkg::CMD_RAW;
         end
         mtg_pkg::MODE_RANGE: begin
            if (req_high_bound == req_low_bound) begin
               new_entry.cmd = mtg_pkg::CMD_EQUAL;
            end else if (req_high_bound < req_low_bound) begin
               new_entry.cmd = mtg_pkg::CMD_ERROR;
            end else begin
               new_entry.cmd = mtg_pkg::CMD_RANGE;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign accept  = push && !full;
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_take && q_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + 2'(accept && keep) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

[hdl/mtg_back.sv]
// mtg_back: seeding, twisting, tempering and range mapping over the state RAM
// depends on mtg_pkg and mtg_ram
module mtg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mtg_pkg::cfg_type      cfg,
   input  logic                  q_valid,
   input  mtg_pkg::entry_type    q_entry,
   output logic                  q_take,
   output logic                  empty,
   input  logic                  pop,
   output logic [31:0]           rsp_random_word,
   output logic signed [31:0]    rsp_ranged_value,
   output logic                  rsp_range_error
);

   localparam int AW = mtg_pkg::ADDR_W;
   localparam int IW = mtg_pkg::IDX_W;
   localparam int DW = mtg_pkg::DISC_W;

   mtg_pkg::back_state_type state_ff, state_in;
   mtg_pkg::entry_type      cur_ff, cur_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  k_ff, k_in;
   logic [DW-1:0]  disc_ff, disc_in;
   logic [31:0]    p_ff, p_in;
   logic [31:0]    a_ff, a_in;
   logic [31:0]    b_ff, b_in;
   logic [31:0]    word_ff, word_in;
   logic [63:0]    prod_ff, prod_in;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_word_ff, out_word_in;
   logic [31:0]    out_value_ff, out_value_in;
   logic           out_error_ff, out_error_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [31:0]    wr_data, rd_data;
   logic [AW-1:0]  nb_addr, pt_addr;
   logic [AW:0]    pt_sum;
   logic [31:0]    tw_y, tw_v, tempered, seed_v, hi_part;
   logic           out_set;

   mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::STATE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      nb_addr  = (k_ff == AW'(mtg_pkg::STATE_DEPTH - 1)) ? '0 : k_ff + AW'(1);
      pt_sum   = {1'b0, k_ff} + (AW+1)'(mtg_pkg::MID_MOD);
      pt_addr  = (pt_sum >= (AW+1)'(mtg_pkg::STATE_DEPTH))
               ? AW'(pt_sum - (AW+1)'(mtg_pkg::STATE_DEPTH)) : pt_sum[AW-1:0];
      tw_y     = (a_ff & mtg_pkg::UPPER_BIT) | (b_ff & mtg_pkg::LOWER_BITS);
      tw_v     = rd_data ^ (tw_y >> 1) ^ (tw_y[0] ? cfg.twist_matrix : 32'd0);
      tempered = mtg_pkg::temper(rd_data, cfg);
      seed_v   = prod_ff[31:0] + 32'(k_ff);
      hi_part  = prod_ff[63:32] + (cur_ff.span[32] ? word_ff : 32'd0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtg_pkg::B_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               unique case (q_entry.cmd) inside
                  mtg_pkg::CMD_SEED:                    state_in = mtg_pkg::B_SEED_MUL;
                  mtg_pkg::CMD_RAW, mtg_pkg::CMD_RANGE: state_in = mtg_pkg::B_DRAW;
                  default:                              state_in = mtg_pkg::B_IDLE;
               endcase
            end
         end
         mtg_pkg::B_SEED_MUL: state_in = mtg_pkg::B_SEED_WR;
         mtg_pkg::B_SEED_WR: begin
            state_in = (k_ff == AW'(mtg_pkg::STATE_DEPTH - 1))
                     ? mtg_pkg::B_DRAW : mtg_pkg::B_SEED_MUL;
         end
         mtg_pkg::B_DRAW: begin
            state_in = (idx_ff >= IW'(mtg_pkg::STATE_DEPTH))
                     ? mtg_pkg::B_TW_A : mtg_pkg::B_RD_DATA;
         end
         mtg_pkg::B_TW_A: state_in = mtg_pkg::B_TW_B;
         mtg_pkg::B_TW_B: state_in = mtg_pkg::B_TW_C;
         mtg_pkg::B_TW_C: state_in = mtg_pkg::B_TW_W;
         mtg_pkg::B_TW_W: begin
            state_in = (k_ff == AW'(mtg_pkg::STATE_DEPTH - 1))
                     ? mtg_pkg::B_DRAW : mtg_pkg::B_TW_A;
         end
         mtg_pkg::B_RD_DATA: begin
            if (disc_ff != '0) begin
               state_in = (disc_ff == DW'(1)) ? mtg_pkg::B_IDLE : mtg_pkg::B_DRAW;
            end else if (cur_ff.cmd == mtg_pkg::CMD_RANGE) begin
               state_in = mtg_pkg::B_MUL;
            end else begin
               state_in = mtg_pkg::B_IDLE;
            end
         end
         mtg_pkg::B_MUL: state_in = mtg_pkg::B_ADD;
         mtg_pkg::B_ADD: state_in = mtg_pkg::B_IDLE;
         default: state_in = mtg_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      disc_in      = disc_ff;
      p_in         = p_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      word_in      = word_ff;
      prod_in      = prod_ff;
      out_word_in  = out_word_ff;
      out_value_in = out_value_ff;
      out_error_in = out_error_ff;
      out_set      = 1'b0;
      q_take       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = tw_v;
      rd_addr      = k_ff;
      unique case (state_ff)
         mtg_pkg::B_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               q_take = 1'b1;
               cur_in = q_entry;
               unique case (q_entry.cmd)
                  mtg_pkg::CMD_SEED: begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = q_entry.data;
                     p_in    = q_entry.data;
                     k_in    = AW'(1);
                  end
                  mtg_pkg::CMD_EQUAL: begin
                     out_set      = 1'b1;
                     out_word_in  = '0;
                     out_value_in = q_entry.data;
                     out_error_in = 1'b0;
                  end
                  mtg_pkg::CMD_ERROR: begin
                     out_set      = 1'b1;
                     out_word_in  = '0;
                     out_value_in = mtg_pkg::UPPER_BIT;
                     out_error_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mtg_pkg::B_SEED_MUL: begin
            prod_in = 64'(p_ff ^ (p_ff >> mtg_pkg::SEED_SHIFT)) * 64'(mtg_pkg::SEED_FACTOR);
         end
         mtg_pkg::B_SEED_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = seed_v;
            p_in    = seed_v;
            k_in    = k_ff + AW'(1);
            if (k_ff == AW'(mtg_pkg::STATE_DEPTH - 1)) begin
               idx_in  = IW'(mtg_pkg::STATE_DEPTH);
               disc_in = DW'(mtg_pkg::DISCARD_COUNT);
            end
         end
         mtg_pkg::B_DRAW: begin
            if (idx_ff >= IW'(mtg_pkg::STATE_DEPTH)) begin
               k_in = '0;
            end else begin
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + IW'(1);
            end
         end
         mtg_pkg::B_TW_A: rd_addr = k_ff;
         mtg_pkg::B_TW_B: begin
            rd_addr = nb_addr;
            a_in    = rd_data;
         end
         mtg_pkg::B_TW_C: begin
            rd_addr = pt_addr;
            b_in    = rd_data;
         end
         mtg_pkg::B_TW_W: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = tw_v;
            k_in    = nb_addr;
            if (k_ff == AW'(mtg_pkg::STATE_DEPTH - 1)) begin
               idx_in = '0;
            end
         end
         mtg_pkg::B_RD_DATA: begin
            word_in = tempered;
            if (disc_ff != '0) begin
               disc_in = disc_ff - DW'(1);
            end else if (cur_ff.cmd != mtg_pkg::CMD_RANGE) begin
               out_set      = 1'b1;
               out_word_in  = tempered;
               out_value_in = '0;
               out_error_in = 1'b0;
            end
         end
         mtg_pkg::B_MUL: begin
            prod_in = 64'(cur_ff.span[31:0]) * 64'(word_ff);
         end
         mtg_pkg::B_ADD: begin
            out_set      = 1'b1;
            out_word_in  = word_ff;
            out_value_in = cur_ff.data + hi_part;
            out_error_in = 1'b0;
         end
         default: begin
         end
      endcase
      out_valid_in = out_set ? 1'b1 : ((pop && out_valid_ff) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtg_pkg::B_IDLE;
         idx_ff       <= IW'(mtg_pkg::STATE_DEPTH);
         disc_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         disc_ff      <= disc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      word_ff      <= word_in;
      prod_ff      <= prod_in;
      out_word_ff  <= out_word_in;
      out_value_ff <= out_value_in;
      out_error_ff <= out_error_in;
   end

   assign empty            = !out_valid_ff;
   assign rsp_random_word  = out_word_ff;
   assign rsp_ranged_value = out_value_ff;
   assign rsp_range_error  = out_error_ff;

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for the mersenne_twister_generator block
// drives requests and register writes, predicts every result word and checks it
// depends on mtg_pkg and the mersenne_twister_generator rtl
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      logic [1:0]         mode;
      logic [31:0]        seed;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } request_type;

   typedef struct {
      logic [31:0]        word;
      logic signed [31:0] ranged;
      logic               err;
   } result_type;

   logic clock, reset;
   logic push, full, empty, pop;
   logic [1:0] req_mode;
   logic [31:0] req_seed_value;
   logic signed [31:0] req_low_bound, req_high_bound;
   logic [31:0] rsp_random_word;
   logic signed [31:0] rsp_ranged_value;
   logic rsp_range_error;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   request_type pending_reqs[$];
   result_type  expected_words[$];

   // predictor state
   logic [31:0] mt_store[mtg_pkg::STATE_DEPTH];
   int          mt_index;
   logic [31:0] cfg_twist, cfg_mask_b, cfg_mask_c;

   int send_idle, recv_idle;
   int mismatches;
   int results_seen;
   int hold_left;
   bit hold_done;

   mersenne_twister_generator u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_seed_value(req_seed_value),
      .req_low_bound(req_low_bound), .req_high_bound(req_high_bound),
      .empty(empty), .pop(pop), .rsp_random_word(rsp_random_word),
      .rsp_ranged_value(rsp_ranged_value), .rsp_range_error(rsp_range_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   function automatic void twist_store();
      logic [31:0] y, v;
      for (int k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
         y = (mt_store[k] & mtg_pkg::UPPER_BIT)
           | (mt_store[(k + 1) % mtg_pkg::STATE_DEPTH] & mtg_pkg::LOWER_BITS);
         v = mt_store[(k + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_DEPTH] ^ (y >> 1);
         if (y[0]) v = v ^ cfg_twist;
         mt_store[k] = v;
      end
      mt_index = 0;
   endfunction

   function automatic logic [31:0] next_tempered();
      logic [31:0] y;
      if (mt_index >= mtg_pkg::STATE_DEPTH) twist_store();
      y = mt_store[mt_index];
      mt_index++;
      y = y ^ (y >> mtg_pkg::SHIFT_U);
      y = y ^ ((y << mtg_pkg::SHIFT_S) & cfg_mask_b);
      y = y ^ ((y << mtg_pkg::SHIFT_T) & cfg_mask_c);
      y = y ^ (y >> mtg_pkg::SHIFT_L);
      return y;
   endfunction

   function automatic void seed_store(logic [31:0] seed);
      logic [31:0] p;
      mt_store[0] = seed;
      for (int i = 1; i < mtg_pkg::STATE_DEPTH; i++) begin
         p = mt_store[i - 1];
         mt_store[i] = mtg_pkg::SEED_FACTOR * (p ^ (p >> mtg_pkg::SEED_SHIFT)) + i;
      end
      mt_index = mtg_pkg::STATE_DEPTH;
      for (int n = 0; n < mtg_pkg::DISCARD_COUNT; n++) void'(next_tempered());
   endfunction

   function automatic void predict_request(request_type r);
      result_type res;
      longint lo, hi;
      logic [63:0] span, prod;
      res = '{word: 32'd0, ranged: 32'sd0, err: 1'b0};
      lo = r.lo;
      hi = r.hi;
      case (r.mode)
         mtg_pkg::MODE_SEED: seed_store(r.seed);
         mtg_pkg::MODE_RAW: begin
            res.word = next_tempered();
            expected_words.push_back(res);
         end
         mtg_pkg::MODE_RANGE: begin
            if (hi == lo) begin
               res.ranged = r.lo;
            end else if (hi < lo) begin
               res.ranged = mtg_pkg::UPPER_BIT;
               res.err = 1'b1;
            end else begin
               res.word = next_tempered();
               span = hi - lo + 1;
               prod = span * {32'd0, res.word};
               res.ranged = 32'(lo + longint'(prod >> 32));
            end
            expected_words.push_back(res);
         end
         default: ;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      request_type r;
      logic        next_push;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (push) begin
            r = '{mode: req_mode, seed: req_seed_value, lo: req_low_bound,
                  hi: req_high_bound};
            predict_request(r);
         end
         next_push = 1'b0;
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
            r = pending_reqs.pop_front();
            req_mode <= r.mode;
            req_seed_value <= r.seed;
            req_low_bound <= r.lo;
            req_high_bound <= r.hi;
            next_push = 1'b1;
         end
         push <= next_push;
      end
   end

   // result monitor, also owns the long receiver hold-off
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", rsp_random_word);
            end else begin
               e = expected_words.pop_front();
               if (e.word !== rsp_random_word || e.ranged !== rsp_ranged_value ||
                   e.err !== rsp_range_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h %h %b, got %h %h %b",
                              e.word, e.ranged, e.err, rsp_random_word,
                              rsp_ranged_value, rsp_range_error);
               end
            end
         end
         if (!hold_done && results_seen == 60) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         mtg_pkg::REG_TWIST:   cfg_twist = value;
         mtg_pkg::REG_TEMPERB: cfg_mask_b = value;
         default:              cfg_mask_c = value;
      endcase
      @(posedge clock);
      if (prdata !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d: expected %h, got %h", idx, value, prdata);
      end
   endtask

   task automatic queue_req(logic [1:0] m, logic [31:0] s, logic [31:0] l, logic [31:0] h);
      pending_reqs.push_back('{mode: m, seed: s, lo: l, hi: h});
   endtask

   task automatic settle();
      while (pending_reqs.size() > 0 || push || expected_words.size() > 0)
         @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      int pick;
      logic [31:0] a, b;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         a = $urandom;
         b = $urandom;
         if (pick < 2) begin
            queue_req(mtg_pkg::MODE_SEED, a, a, b);
         end else if (pick < 5) begin
            queue_req(mtg_pkg::MODE_NONE, a, a, b);
         end else if (pick < 50) begin
            queue_req(mtg_pkg::MODE_RAW, a, a, b);
         end else begin
            case ($urandom_range(5))
               0: b = a;
               1: b = a + $urandom_range(15);
               2: b = a - $urandom_range(1, 100);
               default: ;
            endcase
            queue_req(mtg_pkg::MODE_RANGE, $urandom, a, b);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_mode = mtg_pkg::MODE_SEED;
      req_seed_value = 32'd0;
      req_low_bound = 32'sd0;
      req_high_bound = 32'sd0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 4'd0;
      pwdata = 32'd0;
      mismatches = 0;
      results_seen = 0;
      hold_left = 0;
      hold_done = 1'b0;
      mt_index = mtg_pkg::STATE_DEPTH;
      cfg_twist = 32'h9908_B0DF;
      cfg_mask_b = 32'h9D2C_5680;
      cfg_mask_c = 32'hEFC6_0000;
      send_idle = 36;
      recv_idle = 59;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_reg(mtg_pkg::REG_TWIST, 32'h9908_B0DF);
      write_reg(mtg_pkg::REG_TEMPERB, 32'h9D2C_5680);
      write_reg(mtg_pkg::REG_TEMPERC, 32'hEFC6_0000);

      // directed: seed extremes, every mode, bound corner cases
      queue_req(mtg_pkg::MODE_SEED, 32'd0, 32'd0, 32'd0);
      queue_req(mtg_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
      queue_req(mtg_pkg::MODE_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(mtg_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
      queue_req(mtg_pkg::MODE_SEED, 32'd5489, 32'd0, 32'd0);
      queue_req(mtg_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'd7, 32'd7);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'h8000_0000, 32'h8000_0000);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'd1, 32'd0);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'd0, 32'd1);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'hFFFF_FFF0, 32'd16);
      queue_req(mtg_pkg::MODE_RANGE, 32'd0, 32'h8000_0000, 32'h8000_0001);
      queue_req(mtg_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(mtg_pkg::MODE_RAW, 32'd0, 32'd0, 32'd0);
      queue_random(400);
      settle();

      send_idle = 59;
      recv_idle = 36;
      write_reg(mtg_pkg::REG_TWIST, 32'hFFFF_FFFF);
      write_reg(mtg_pkg::REG_TEMPERB, 32'hFFFF_FFFF);
      write_reg(mtg_pkg::REG_TEMPERC, 32'hFFFF_FFFF);
      queue_req(mtg_pkg::MODE_SEED, $urandom, 32'd0, 32'd0);
      queue_random(400);
      settle();

      send_idle = 0;
      recv_idle = 0;
      write_reg(mtg_pkg::REG_TWIST, 32'd0);
      write_reg(mtg_pkg::REG_TEMPERB, 32'd0);
      write_reg(mtg_pkg::REG_TEMPERC, 32'd0);
      queue_req(mtg_pkg::MODE_SEED, $urandom, 32'd0, 32'd0);
      queue_random(400);
      settle();

      write_reg(mtg_pkg::REG_TWIST, $urandom);
      write_reg(mtg_pkg::REG_TEMPERB, $urandom);
      write_reg(mtg_pkg::REG_TEMPERC, $urandom);
      queue_req(mtg_pkg::MODE_SEED, $urandom, 32'd0, 32'd0);
      queue_random(400);
      settle();

      if (mismatches == 0 && expected_words.size() == 0)
         $display("mersenne_twister_generator test passed");
      else
         $display("mersenne_twister_generator test failed");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("mersenne_twister_generator test failed");
      $finish;
   end

endmodule
